/* design/tta_pkg.sv */
// Shared types and constants for the tensor transpose address generator.
// No dependencies; imported by tta_cfg and tensor_transpose_address_gen.
`default_nettype none

package tta_pkg;

  localparam int DEF_MAX_RANK   = 6;
  localparam int DEF_INDEX_BITS = 32;

  localparam int FIELD_BITS    = 32;  // out_index and source_index
  localparam int STATUS_BITS   = 2;
  localparam int M_TDATA_BITS  = 40;  // 34 bits of fields filled up to bytes
  localparam int DIM_BITS      = 16;
  localparam int RANK_BITS     = 3;
  localparam int ORDER_BITS    = 18;
  localparam int AXIS_SEL_BITS = 3;
  localparam int AXIS_REGS     = 6;
  localparam int AXIS_SLOTS    = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;

  localparam logic [RANK_BITS-1:0]  RANK_RESET  = 3'd1;
  localparam logic [ORDER_BITS-1:0] ORDER_RESET = 18'd181896;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RANK  = 3'd0,
    REG_ORDER = 3'd1,
    REG_DIM0  = 3'd2,
    REG_DIM1  = 3'd3,
    REG_DIM2  = 3'd4,
    REG_DIM3  = 3'd5,
    REG_DIM4  = 3'd6,
    REG_DIM5  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic busy;  // derived strides and count are being recomputed
    logic bad;   // rank, permutation or element count is unusable
  } cfg_stat_t;

endpackage

`default_nettype wire

/* design/tta_cfg.sv */
// Configuration registers and the sequencer that derives element count and strides.
// Depends on tta_pkg.
`default_nettype none

module tta_cfg #(
  parameter int MAX_RANK   = tta_pkg::DEF_MAX_RANK,
  parameter int INDEX_BITS = tta_pkg::DEF_INDEX_BITS,
  parameter int STEP_BITS  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tta_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tta_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic [tta_pkg::RANK_BITS-1:0]           rank,
  output logic [tta_pkg::AXIS_SEL_BITS-1:0]       perm [MAX_RANK],
  output logic [INDEX_BITS:0]                     count,
  output logic [INDEX_BITS:0]                     src_stride [MAX_RANK],
  output logic [INDEX_BITS:0]                     dst_stride [MAX_RANK],
  output tta_pkg::cfg_stat_t                      stat
);
  import tta_pkg::*;

  localparam int CNT_W  = INDEX_BITS + 1;
  localparam int PROD_W = CNT_W + DIM_BITS;
  localparam logic [PROD_W-1:0] LIMIT = PROD_W'(1) << INDEX_BITS;
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(MAX_RANK - 1);

  logic [RANK_BITS-1:0]  rank_r;
  logic [ORDER_BITS-1:0] order_r;
  logic [DIM_BITS-1:0]   dim_r [AXIS_REGS];
  logic [DIM_BITS-1:0]   dim_ext [AXIS_SLOTS];
  logic [AXIS_SEL_BITS-1:0] perm_w [MAX_RANK];

  logic                  busy;
  logic [STEP_BITS-1:0]  st;
  logic [STEP_BITS-1:0]  di;
  logic                  ovf;
  logic [CNT_W-1:0]      sacc;
  logic [CNT_W-1:0]      dacc;
  logic [PROD_W-1:0]     cprod;
  logic [PROD_W-1:0]     sprod;
  logic [PROD_W-1:0]     dprod;
  logic                  asc_live;
  logic                  desc_live;
  logic                  bad_perm;
  logic [AXIS_SLOTS-1:0] used;

  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < AXIS_SLOTS; i++) begin
      dim_ext[i] = (i < AXIS_REGS) ? dim_r[i] : DIM_BITS'(1);
    end
  end

  // Output axes past the register's six entries read as source axis zero.
  for (genvar j = 0; j < MAX_RANK; j++) begin : g_perm
    if (j < AXIS_REGS) begin : g_reg
      assign perm_w[j] = order_r[AXIS_SEL_BITS*j +: AXIS_SEL_BITS];
    end else begin : g_zero
      assign perm_w[j] = '0;
    end
  end

  always_comb begin
    used     = '0;
    bad_perm = (rank_r == '0) || ({1'b0, rank_r} > 4'(MAX_RANK));
    for (int j = 0; j < MAX_RANK; j++) begin
      if (4'(j) < {1'b0, rank_r}) begin
        if ((perm_w[j] >= rank_r) || used[perm_w[j]]) begin
          bad_perm = 1'b1;
        end else begin
          used[perm_w[j]] = 1'b1;
        end
      end
    end
  end

  // The count is built from the outermost axis inward so that an overflow
  // before a zero extent still marks the shape invalid. Strides are built
  // from the innermost axis outward in the same steps.
  always_comb begin
    di        = LAST_STEP - st;
    asc_live  = !ovf && (4'(st) < {1'b0, rank_r});
    desc_live = 4'(di) < {1'b0, rank_r};
    cprod     = PROD_W'(count) * PROD_W'(dim_ext[AXIS_SEL_BITS'(st)]);
    sprod     = PROD_W'(sacc) * PROD_W'(dim_ext[AXIS_SEL_BITS'(di)]);
    dprod     = PROD_W'(dacc) * PROD_W'(dim_ext[perm_w[di]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_r  <= RANK_RESET;
      order_r <= ORDER_RESET;
      for (int i = 0; i < AXIS_REGS; i++) begin
        dim_r[i] <= DIM_BITS'(1);
      end
      busy  <= 1'b1;
      st    <= '0;
      ovf   <= 1'b0;
      count <= CNT_W'(1);
      sacc  <= CNT_W'(1);
      dacc  <= CNT_W'(1);
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_RANK:  rank_r  <= cfg_data[RANK_BITS-1:0];
        REG_ORDER: order_r <= cfg_data[ORDER_BITS-1:0];
        REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3, REG_DIM4, REG_DIM5: begin
          dim_r[CFG_IDX_BITS'(cfg_index - CFG_IDX_BITS'(REG_DIM0))] <= cfg_data[DIM_BITS-1:0];
        end
      endcase
      busy  <= 1'b1;
      st    <= '0;
      ovf   <= 1'b0;
      count <= CNT_W'(1);
      sacc  <= CNT_W'(1);
      dacc  <= CNT_W'(1);
    end else if (busy) begin
      if (asc_live) begin
        if (cprod > LIMIT) begin
          ovf <= 1'b1;
        end else begin
          count <= cprod[CNT_W-1:0];
        end
      end
      if (desc_live) begin
        src_stride[di] <= sacc;
        dst_stride[di] <= dacc;
        sacc <= sprod[CNT_W-1:0];
        dacc <= dprod[CNT_W-1:0];
      end else begin
        src_stride[di] <= CNT_W'(1);
        dst_stride[di] <= CNT_W'(1);
      end
      if (st == LAST_STEP) begin
        busy <= 1'b0;
      end else begin
        st <= st + STEP_BITS'(1);
      end
    end
  end

  assign rank      = rank_r;
  assign perm      = perm_w;
  assign stat.busy = busy;
  assign stat.bad  = bad_perm || ovf;

endmodule

`default_nettype wire

/* design/tensor_transpose_address_gen.sv */
// Tensor transpose address generator: stream in output indexes, stream out source indexes.
// Depends on tta_pkg and tta_cfg.
//
// Usage. Write the rank, axis order and extents on the cfg channel (index 0 rank,
// 1 axis order, 2..7 extents of axes 0..5). After every write, and after reset,
// the derived strides and element count are rebuilt, during which s_tready is
// low. Then each request on the s channel carries one output linear index and
// yields one response on the m channel: the source linear index and a status
// (ok, index beyond the element count, invalid shape); the index is zero unless
// the status is ok.
// Throughput is one request per cycle while the receiver keeps up and no rebuild
// is running. An accepted request passes an entry check stage; then each output
// coordinate is found by a 16-step restoring division, one compare and subtract
// per pipeline stage, followed by a multiply stage, two adder stages and the
// output register.
// Reset is synchronous and clears all valid bits and loads the register resets.
// When the receiver stalls, a skid register catches the one response in
// flight, the pipeline freezes and s_tready drops; nothing is lost or repeated.
`default_nettype none

module tensor_transpose_address_gen #(
  parameter int MAX_RANK   = tta_pkg::DEF_MAX_RANK,
  parameter int INDEX_BITS = tta_pkg::DEF_INDEX_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [tta_pkg::FIELD_BITS-1:0]     s_tdata,   // [31:0] out_index
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [tta_pkg::M_TDATA_BITS-1:0]        m_tdata,   // [31:0] source_index,
                                                             // [33:32] status, rest zero
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tta_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tta_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tta_pkg::*;

  localparam int STEP_BITS = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int CNT_W     = INDEX_BITS + 1;
  localparam int NDIV      = MAX_RANK * DIM_BITS;
  localparam int CMP_W     = (FIELD_BITS > CNT_W) ? FIELD_BITS + 1 : CNT_W + 1;
  localparam int TW        = (FIELD_BITS > CNT_W + DIM_BITS) ? FIELD_BITS : CNT_W + DIM_BITS;
  localparam int NP        = (MAX_RANK + 1) / 2;
  localparam int MUL_W     = FIELD_BITS + DIM_BITS;

  logic [RANK_BITS-1:0]     rank;
  logic [AXIS_SEL_BITS-1:0] perm [MAX_RANK];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         src_stride [MAX_RANK];
  logic [CNT_W-1:0]         dst_stride [MAX_RANK];
  cfg_stat_t                stat;

  tta_cfg #(
    .MAX_RANK   (MAX_RANK),
    .INDEX_BITS (INDEX_BITS),
    .STEP_BITS  (STEP_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rank       (rank),
    .perm       (perm),
    .count      (count),
    .src_stride (src_stride),
    .dst_stride (dst_stride),
    .stat       (stat)
  );

  // The whole pipeline moves together; it stops only while the skid is full.
  logic skid_v;
  logic en;
  assign en       = !skid_v;
  assign s_tready = en && !stat.busy;

  // Entry stage: status check.
  logic                  v0;
  logic [FIELD_BITS-1:0] rem0;
  status_t               st0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0 <= s_tdata;
      if (stat.bad) begin
        st0 <= ST_INVALID;
      end else if (CMP_W'(s_tdata) >= CMP_W'(count)) begin
        st0 <= ST_RANGE;
      end else begin
        st0 <= ST_OK;
      end
    end
  end

  // Division chain: stage n finds bit k of the coordinate of output axis j.
  logic                  dv    [NDIV];
  logic [FIELD_BITS-1:0] drem  [NDIV];
  logic [DIM_BITS-1:0]   dcrd  [NDIV][MAX_RANK];
  status_t               dst   [NDIV];

  for (genvar n = 0; n < NDIV; n++) begin : g_div
    localparam int J = n / DIM_BITS;
    localparam int K = DIM_BITS - 1 - (n % DIM_BITS);

    logic                  in_v;
    logic [FIELD_BITS-1:0] in_rem;
    logic [DIM_BITS-1:0]   in_crd [MAX_RANK];
    logic [DIM_BITS-1:0]   out_crd [MAX_RANK];
    status_t               in_st;
    logic [TW-1:0]         trial;
    logic                  take;

    if (n == 0) begin : g_first
      assign in_v   = v0;
      assign in_rem = rem0;
      assign in_st  = st0;
      always_comb begin
        for (int a = 0; a < MAX_RANK; a++) begin
          in_crd[a] = '0;
        end
      end
    end else begin : g_next
      assign in_v   = dv[n-1];
      assign in_rem = drem[n-1];
      assign in_crd = dcrd[n-1];
      assign in_st  = dst[n-1];
    end

    assign trial = TW'(dst_stride[J]) << K;
    assign take  = (4'(J) < {1'b0, rank}) && (TW'(in_rem) >= trial);

    always_comb begin
      for (int a = 0; a < MAX_RANK; a++) begin
        out_crd[a] = in_crd[a];
      end
      out_crd[J][K] = take;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[n] <= 1'b0;
      end else if (en) begin
        dv[n] <= in_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[n] <= take ? FIELD_BITS'(TW'(in_rem) - trial) : in_rem;
        dst[n]  <= in_st;
        for (int a = 0; a < MAX_RANK; a++) begin
          dcrd[n][a] <= out_crd[a];
        end
      end
    end
  end

  // Product stage: coordinate times source stride of its axis, modulo 2^32.
  logic                  pv;
  status_t               pst;
  logic [FIELD_BITS-1:0] prod [MAX_RANK];
  logic [FIELD_BITS-1:0] sel_stride [MAX_RANK];
  logic [MUL_W-1:0]      mul [MAX_RANK];

  always_comb begin
    for (int a = 0; a < MAX_RANK; a++) begin
      if (perm[a] < AXIS_SEL_BITS'(MAX_RANK - 1) + AXIS_SEL_BITS'(1) || MAX_RANK == AXIS_SLOTS) begin
        sel_stride[a] = FIELD_BITS'(src_stride[perm[a][STEP_BITS-1:0]]);
      end else begin
        sel_stride[a] = '0;
      end
      mul[a] = MUL_W'(dcrd[NDIV-1][a]) * MUL_W'(sel_stride[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= dv[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pst <= dst[NDIV-1];
      for (int a = 0; a < MAX_RANK; a++) begin
        prod[a] <= mul[a][FIELD_BITS-1:0];
      end
    end
  end

  // Two adder stages: pair sums, then the total with the status mask.
  logic                  av;
  status_t               ast;
  logic [FIELD_BITS-1:0] psum [NP];
  logic                  bv;
  logic [M_TDATA_BITS-1:0] bdata;
  logic [FIELD_BITS-1:0] total;

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
      bv <= 1'b0;
    end else if (en) begin
      av <= pv;
      bv <= av;
    end
  end

  always_comb begin
    total = '0;
    for (int p = 0; p < NP; p++) begin
      total = total + psum[p];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ast <= pst;
      for (int p = 0; p < NP; p++) begin
        if (2 * p + 1 < MAX_RANK) begin
          psum[p] <= prod[2*p] + prod[(2*p+1 < MAX_RANK) ? 2*p+1 : 2*p];
        end else begin
          psum[p] <= prod[2*p];
        end
      end
      bdata <= {(M_TDATA_BITS - FIELD_BITS - STATUS_BITS)'(0), ast,
                (ast == ST_OK) ? total : FIELD_BITS'(0)};
    end
  end

  // Output register with a skid stage behind it.
  logic                    b_in;
  logic [M_TDATA_BITS-1:0] skid_data;
  assign b_in = bv && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_v) begin
        m_tvalid <= 1'b1;
        skid_v   <= 1'b0;
      end else begin
        m_tvalid <= b_in;
      end
    end else if (b_in) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      m_tdata <= skid_v ? skid_data : bdata;
    end else if (b_in) begin
      skid_data <= bdata;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> m_tvalid && !s_tready)
    else $error("skid holds a response while the output is empty or input is open");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("request accepted while derived strides are being rebuilt");

  a_fail_zero_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] != ST_OK) |-> (m_tdata[31:0] == '0))
    else $error("nonzero source index with an error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:32] != 2'd3) && (m_tdata[M_TDATA_BITS-1:34] == '0))
    else $error("undefined status code or stray bits on output");

endmodule

`default_nettype wire

/* sim/tensor_transpose_address_gen_tb.sv */
// Self-checking bench for the tensor transpose address generator.
// Depends on tta_pkg and tensor_transpose_address_gen; drives cfg, s and m streams.
`default_nettype none

module tensor_transpose_address_gen_tb;
  import tta_pkg::*;

  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [31:0] src_index;
    status_t     stat;
  } addr_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  // Acceptance seen at the last rising edge.
  logic s_tready_q = 1'b0;

  // Shadow copy of the block's registers.
  logic [2:0]  sh_rank;
  logic [17:0] sh_order;
  logic [15:0] sh_dim [AXIS_REGS];

  logic [31:0]  index_queue [$];
  addr_result_t expected_addrs [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  tensor_transpose_address_gen u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic addr_result_t gather_source(input logic [31:0] out_idx);
    addr_result_t r;
    logic [63:0] dims [8];
    logic [63:0] s_str [8];
    logic [63:0] d_str [8];
    int unsigned perm [8];
    bit used [8];
    logic [63:0] count;
    logic [63:0] idx;
    logic [63:0] src;
    int unsigned rk;
    int unsigned a;
    bit bad;
    count = 1;
    idx = out_idx;
    src = 0;
    rk = sh_rank;
    bad = 0;
    for (int i = 0; i < 8; i++) begin
      dims[i] = (i < AXIS_REGS) ? sh_dim[i] : 1;
      used[i] = 0;
      perm[i] = 0;
    end
    if (rk == 0 || rk > 6) begin
      bad = 1;
    end else begin
      for (int j = 0; j < rk; j++) begin
        a = (sh_order >> (3 * j)) & 7;
        if (a >= rk || used[a]) bad = 1;
        else used[a] = 1;
        perm[j] = a;
      end
      for (int i = 0; i < rk && !bad; i++) begin
        if (dims[i] != 0 && count > (64'h1_0000_0000 / dims[i])) bad = 1;
        else count = count * dims[i];
      end
      if (count > 64'h1_0000_0000) bad = 1;
    end
    r.src_index = '0;
    if (bad) begin
      r.stat = ST_INVALID;
      return r;
    end
    if (idx >= count) begin
      r.stat = ST_RANGE;
      return r;
    end
    for (int i = rk - 1; i >= 0; i--) begin
      if (i == rk - 1) begin
        s_str[i] = 1;
        d_str[i] = 1;
      end else begin
        s_str[i] = s_str[i+1] * dims[i+1];
        d_str[i] = d_str[i+1] * dims[perm[i+1]];
      end
    end
    for (int j = 0; j < rk; j++) begin
      src = src + (idx / d_str[j]) * s_str[perm[j]];
      idx = idx % d_str[j];
    end
    r.src_index = src[31:0];
    r.stat = ST_OK;
    return r;
  endfunction

  task automatic enqueue_index(input logic [31:0] v);
    index_queue.insert(index_queue.size(), v);
  endtask

  // Request driver; also drives m_tready.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready_q) begin
      if (index_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= index_queue.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    s_tready_q <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_addrs.insert(expected_addrs.size(), gather_source(s_tdata));
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    addr_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_addrs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", m_tdata);
      end else begin
        want = expected_addrs.pop_front();
        if (m_tdata[31:0] !== want.src_index || m_tdata[33:32] !== want.stat
            || m_tdata[39:34] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected index %h status %0d, got index %h status %0d",
                     want.src_index, want.stat, m_tdata[31:0], m_tdata[33:32]);
        end
      end
    end
  end

  task automatic write_reg(input reg_index_t ri, input logic [17:0] val);
    @(negedge clk);
    cfg_index <= ri;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ri)
      REG_RANK:  sh_rank = val[2:0];
      REG_ORDER: sh_order = val;
      default:   sh_dim[ri - REG_DIM0] = val[15:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_shape(input logic [2:0] rk, input logic [17:0] ord,
                           input logic [15:0] d0, d1, d2, d3, d4, d5);
    write_reg(REG_RANK, 18'(rk));
    write_reg(REG_ORDER, ord);
    write_reg(REG_DIM0, 18'(d0));
    write_reg(REG_DIM1, 18'(d1));
    write_reg(REG_DIM2, 18'(d2));
    write_reg(REG_DIM3, 18'(d3));
    write_reg(REG_DIM4, 18'(d4));
    write_reg(REG_DIM5, 18'(d5));
  endtask

  task automatic wait_idle();
    while (index_queue.size() > 0 || s_tvalid || expected_addrs.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random valid permutation of the given rank, packed 3 bits per axis.
  function automatic logic [17:0] rand_perm(input int rk);
    int p [6];
    int k, t;
    logic [17:0] o;
    for (int i = 0; i < 6; i++) p[i] = i;
    for (int i = rk - 1; i > 0; i--) begin
      k = $urandom_range(i);
      t = p[i]; p[i] = p[k]; p[k] = t;
    end
    o = 18'($urandom);  // entries above the rank are don't-care
    for (int i = 0; i < rk; i++) o[3*i +: 3] = 3'(p[i]);
    return o;
  endfunction

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(9))
      0:       return 16'($urandom_range(65535, 1));
      1:       return 16'd1;
      default: return 16'($urandom_range(9, 1));
    endcase
  endfunction

  task automatic random_phase(input int n_items);
    int rk;
    logic [63:0] cnt;
    rk = $urandom_range(6, 1);
    set_shape(3'(rk), ($urandom_range(9) == 0) ? 18'($urandom) : rand_perm(rk),
              rand_dim(), rand_dim(), rand_dim(), rand_dim(), rand_dim(), rand_dim());
    if ($urandom_range(19) == 0) write_reg(REG_RANK, $urandom_range(1) ? 18'd0 : 18'd7);
    cnt = 1;
    for (int i = 0; i < sh_rank && i < 6; i++) cnt = cnt * sh_dim[i];
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) == 0 || cnt == 0 || cnt > 64'hFFFF_FFFF)
        enqueue_index($urandom);
      else
        enqueue_index(32'($urandom) % cnt[31:0]);
    end
    wait_idle();
  endtask

  initial begin
    sh_rank = RANK_RESET;
    sh_order = ORDER_RESET;
    for (int i = 0; i < AXIS_REGS; i++) sh_dim[i] = 16'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset shape: a single element.
    enqueue_index(32'd0);
    enqueue_index(32'd1);
    enqueue_index(32'hFFFF_FFFF);
    wait_idle();

    // 2x3 matrix transpose, every element plus one past the end.
    set_shape(3'd2, 18'o01, 16'd2, 16'd3, 16'd1, 16'd1, 16'd1, 16'd1);
    for (int i = 0; i < 7; i++) enqueue_index(i);
    wait_idle();
    // Full rank reversal over six small extents.
    set_shape(3'd6, 18'o012345, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7);
    enqueue_index(32'd0);
    enqueue_index(32'd5039);
    enqueue_index(32'd1234);
    wait_idle();
    // Element count just under 2^32, then past it.
    set_shape(3'd2, 18'o01, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1);
    enqueue_index(32'hFFFF_FFFF);
    enqueue_index(32'h8000_0001);
    wait_idle();
    set_shape(3'd3, 18'o210, 16'hFFFF, 16'hFFFF, 16'd2, 16'd1, 16'd1, 16'd1);
    enqueue_index(32'd3);
    wait_idle();
    // Zero extent, duplicate axis, axis beyond rank, bad ranks.
    set_shape(3'd2, 18'o10, 16'd0, 16'd5, 16'd1, 16'd1, 16'd1, 16'd1);
    enqueue_index(32'd0);
    wait_idle();
    write_reg(REG_ORDER, 18'o00);
    enqueue_index(32'd0);
    wait_idle();
    write_reg(REG_ORDER, 18'o72);
    enqueue_index(32'd0);
    wait_idle();
    write_reg(REG_RANK, 18'd0);
    enqueue_index(32'd0);
    wait_idle();
    write_reg(REG_RANK, 18'd7);
    enqueue_index(32'd0);
    wait_idle();

    send_idle_pct = 24; recv_idle_pct = 48;
    for (int p = 0; p < 10; p++) random_phase(42);
    send_idle_pct = 48; recv_idle_pct = 24;
    for (int p = 0; p < 10; p++) random_phase(42);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int p = 0; p < 10; p++) random_phase(42);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
